>>> hdl/tnon_pkg.sv
// Shared constants, codes and the descriptor type of the telnet option negotiator.
package tnon_pkg;

    // Telnet command codes
    localparam logic [7:0] C_IAC  = 8'd255;
    localparam logic [7:0] C_DONT = 8'd254;
    localparam logic [7:0] C_DO   = 8'd253;
    localparam logic [7:0] C_WONT = 8'd252;
    localparam logic [7:0] C_WILL = 8'd251;
    localparam logic [7:0] C_SB   = 8'd250;
    localparam logic [7:0] C_NOP  = 8'd241;
    localparam logic [7:0] C_SE   = 8'd240;

    // Option codes
    localparam logic [7:0] OPT_ECHO   = 8'd1;
    localparam logic [7:0] OPT_SGA    = 8'd3;
    localparam logic [7:0] OPT_LOGOUT = 8'd18;

    // Special data bytes
    localparam logic [7:0] CH_NUL = 8'd0;
    localparam logic [7:0] CH_EOT = 8'd4;
    localparam logic [7:0] CH_TAB = 8'd9;
    localparam logic [7:0] CH_VT  = 8'd11;

    // Input function codes
    localparam logic [1:0] FUNC_BYTE = 2'd0;
    localparam logic [1:0] FUNC_TICK = 2'd1;
    localparam logic [1:0] FUNC_SENT = 2'd2;
    localparam logic [1:0] FUNC_NONE = 2'd3;

    // Result kind codes
    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_SEND = 2'd1;
    localparam logic [1:0] KIND_END  = 2'd2;

    localparam logic [15:0] KEEPALIVE_RST = 16'd1000;
    localparam logic [15:0] IDLE_MAX      = 16'hFFFF;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Work for the back end: which result sequence to play out
    typedef enum logic [2:0] {
        OP_DATA,       // one data byte to the shell (byte in opt)
        OP_SEND3,      // IAC cmd opt
        OP_SEND3_END,  // IAC cmd opt, then session end
        OP_END,        // session end only
        OP_NOP         // IAC NOP keepalive
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] cmd;
        logic [7:0] opt;
        logic       echo;
    } t_desc;

endpackage

>>> hdl/tnon_front.sv
// Front end: accepts input words, runs the telnet parser and queues result work.
module tnon_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [1:0]       i_func,
    input  logic [7:0]       i_byte,
    input  logic             i_cfg_valid,
    input  logic [15:0]      i_cfg_data,
    input  logic             i_full,
    output logic             o_ready,
    output logic             o_push,
    output tnon_pkg::t_desc  o_desc
);
    import tnon_pkg::*;

    typedef enum logic [2:0] {
        PS_DATA, PS_IAC, PS_DO, PS_DONT, PS_WILL, PS_WONT, PS_SB
    } t_pstate;

    t_pstate     r_state, n_state;
    logic        r_echo, n_echo;
    logic [15:0] r_idle, n_idle;
    logic [15:0] r_keep;
    logic        accept;
    logic        check;
    logic        push;
    t_desc       desc;

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;

    // Parser step
    always_comb begin
        n_state  = r_state;
        n_echo   = r_echo;
        n_idle   = r_idle;
        check    = 1'b0;
        push     = 1'b0;
        desc.op  = OP_DATA;
        desc.cmd = C_WILL;
        desc.opt = i_byte;
        if (accept) begin
            unique case (i_func)
                FUNC_TICK: begin
                    if (r_idle != IDLE_MAX) n_idle = r_idle + 16'd1;
                end
                FUNC_SENT: n_idle = '0;
                FUNC_BYTE: begin
                    check = 1'b1;
                    unique case (r_state)
                        PS_DATA: begin
                            if (i_byte == C_IAC) begin
                                n_state = PS_IAC;
                            end else if (i_byte == CH_NUL || i_byte == CH_TAB ||
                                         i_byte == CH_VT) begin
                                // dropped
                            end else if (i_byte == CH_EOT) begin
                                push     = 1'b1;
                                desc.op  = OP_SEND3_END;
                                desc.cmd = C_WILL;
                                desc.opt = OPT_LOGOUT;
                                n_idle   = '0;
                                check    = 1'b0;
                            end else begin
                                push  = 1'b1;
                                check = 1'b0;
                            end
                        end
                        PS_IAC: begin
                            n_state = PS_DATA;
                            if (i_byte == C_DO) n_state = PS_DO;
                            else if (i_byte == C_DONT) n_state = PS_DONT;
                            else if (i_byte == C_WILL) n_state = PS_WILL;
                            else if (i_byte == C_WONT) n_state = PS_WONT;
                            else if (i_byte == C_SB) n_state = PS_SB;
                            else if (i_byte == C_IAC) begin
                                push  = 1'b1;
                                check = 1'b0;
                            end
                        end
                        PS_DO: begin
                            n_state = PS_DATA;
                            push    = 1'b1;
                            desc.op = OP_SEND3;
                            n_idle  = '0;
                            check   = 1'b0;
                            if (i_byte == OPT_ECHO) begin
                                n_echo = 1'b1;
                            end else if (i_byte == OPT_SGA) begin
                                // plain WILL reply
                            end else if (i_byte == OPT_LOGOUT) begin
                                desc.op = OP_SEND3_END;
                            end else begin
                                desc.cmd = C_WONT;
                            end
                        end
                        PS_DONT: begin
                            n_state  = PS_DATA;
                            push     = 1'b1;
                            desc.op  = OP_SEND3;
                            desc.cmd = C_WONT;
                            n_idle   = '0;
                            check    = 1'b0;
                            if (i_byte == OPT_ECHO) n_echo = 1'b0;
                        end
                        PS_WILL, PS_WONT: n_state = PS_DATA;
                        PS_SB: begin
                            if (i_byte == C_SE) n_state = PS_DATA;
                        end
                        default: begin
                            n_state = PS_DATA;
                            push    = 1'b1;
                            desc.op = OP_END;
                            check   = 1'b0;
                        end
                    endcase
                    // Keepalive after a byte that produced no result
                    if (check && r_idle > r_keep) begin
                        push    = 1'b1;
                        desc.op = OP_NOP;
                        n_idle  = '0;
                    end
                end
                default: ;
            endcase
        end
        desc.echo = n_echo;
    end

    // State and config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= PS_DATA;
            r_echo  <= 1'b0;
            r_idle  <= '0;
            r_keep  <= KEEPALIVE_RST;
        end else begin
            r_state <= n_state;
            r_echo  <= n_echo;
            r_idle  <= n_idle;
            if (i_cfg_valid) r_keep <= i_cfg_data;
        end
    end

    assign o_push = push;
    assign o_desc = desc;

endmodule

>>> hdl/tnon_fifo.sv
// Short descriptor queue between parser front end and result back end.
module tnon_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  tnon_pkg::t_desc  i_desc,
    input  logic             i_pop,
    output tnon_pkg::t_desc  o_desc,
    output logic             o_full,
    output logic             o_empty
);
    import tnon_pkg::*;

    localparam logic [QUEUE_AW:0] DEPTH_C = (QUEUE_AW + 1)'(QUEUE_DEPTH);

    t_desc               r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr;
    logic [QUEUE_AW-1:0] r_rd;
    logic [QUEUE_AW:0]   r_cnt;

    assign o_full  = (r_cnt == DEPTH_C);
    assign o_empty = (r_cnt == '0);
    assign o_desc  = r_mem[r_rd];

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_desc;
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop)  r_rd <= r_rd + 1'b1;
            if (i_push && !i_pop)      r_cnt <= r_cnt + 1'b1;
            else if (!i_push && i_pop) r_cnt <= r_cnt - 1'b1;
        end
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= DEPTH_C) else $error("queue count beyond depth");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full) else $error("push into full queue");
    a_cnt_inc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> r_cnt == $past(r_cnt) + 1'b1)
        else $error("queue count did not follow push");
`endif

endmodule

>>> hdl/tnon_back.sv
// Back end: plays queued descriptors out as result words through an output register.
module tnon_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tnon_pkg::t_desc  i_desc,
    input  logic             i_empty,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [1:0]       o_kind,
    output logic [7:0]       o_byte,
    output logic             o_echo,
    output logic             o_last
);
    import tnon_pkg::*;

    logic [1:0] r_idx;
    logic       r_valid;
    logic [1:0] r_kind;
    logic [7:0] r_byte;
    logic       r_echo;
    logic       r_last;
    logic       load;
    logic [1:0] e_kind;
    logic [7:0] e_byte;
    logic       e_last;

    assign load  = !i_empty && (!r_valid || i_ready);
    assign o_pop = load && e_last;

    // Element selection for the current descriptor
    always_comb begin
        e_kind = KIND_SEND;
        e_byte = C_IAC;
        e_last = 1'b0;
        unique case (i_desc.op)
            OP_DATA: begin
                e_kind = KIND_DATA;
                e_byte = i_desc.opt;
                e_last = 1'b1;
            end
            OP_SEND3, OP_SEND3_END: begin
                unique case (r_idx)
                    2'd0: e_byte = C_IAC;
                    2'd1: e_byte = i_desc.cmd;
                    2'd2: begin
                        e_byte = i_desc.opt;
                        e_last = (i_desc.op == OP_SEND3);
                    end
                    default: begin
                        e_kind = KIND_END;
                        e_byte = '0;
                        e_last = 1'b1;
                    end
                endcase
            end
            OP_END: begin
                e_kind = KIND_END;
                e_byte = '0;
                e_last = 1'b1;
            end
            OP_NOP: begin
                e_byte = (r_idx == 2'd0) ? C_IAC : C_NOP;
                e_last = (r_idx != 2'd0);
            end
            default: begin
                e_kind = KIND_END;
                e_byte = '0;
                e_last = 1'b1;
            end
        endcase
    end

    // Output register and element counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_idx   <= e_last ? 2'd0 : r_idx + 2'd1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind <= e_kind;
            r_byte <= e_byte;
            r_echo <= i_desc.echo;
            r_last <= e_last;
        end
    end

    assign o_valid = r_valid;
    assign o_kind  = r_kind;
    assign o_byte  = r_byte;
    assign o_echo  = r_echo;
    assign o_last  = r_last;

`ifndef SYNTHESIS
    a_mid_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx != 2'd0 |-> !i_empty) else $error("descriptor left mid sequence");
    a_end_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_kind == KIND_END) |-> (r_byte == 8'd0 && r_last))
        else $error("bad session end word");
    a_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_last) |-> r_kind == KIND_SEND)
        else $error("non-final word is not a peer send");
`endif

endmodule

>>> hdl/telnet_option_negotiator.sv
// Top level of the telnet option negotiator: front end, queue and back end.
// Usage:
//   Input stream (s): one word per event. tuser = func (tick, byte, other
//   traffic sent), tdata = received byte. Output stream (m): result words,
//   tuser = kind (shell data, byte to peer, session end), tdata = out byte
//   and echo flag, tlast marks the final word caused by one input word.
//   Config channel: writes the 16-bit keepalive threshold in milliseconds;
//   always ready, write only while no work is in flight.
// Timing:
//   The parser handles one input word per cycle while the queue is not full.
//   The first result of a word passes through the descriptor queue and the
//   output register before it appears on m. A word gives up to 4 results.
//   A four-entry descriptor queue lets input run ahead of a busy output.
// Reset and stall:
//   Reset (synchronous, active low) returns the parser to data state, clears
//   the echo flag and idle count, and loads a keepalive threshold of 1000.
//   When the receiver holds tready low, the output word holds, the queue fills
//   and s_tready drops once the queue is full.
module telnet_option_negotiator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] byte_value
    input  logic [1:0]  i_s_tuser,   // [1:0] func
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [7:0] out_byte, [8] echo_on, [15:9] zero
    output logic [1:0]  o_m_tuser,   // [1:0] kind
    output logic        o_m_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);
    import tnon_pkg::*;

    logic       push;
    logic       pop;
    logic       full;
    logic       empty;
    t_desc      fr_desc;
    t_desc      q_desc;
    logic [7:0] out_byte;
    logic       echo_on;

    assign o_cfg_ready = 1'b1;

    tnon_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_tvalid),
        .i_func      (i_s_tuser),
        .i_byte      (i_s_tdata),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_full      (full),
        .o_ready     (o_s_tready),
        .o_push      (push),
        .o_desc      (fr_desc)
    );

    tnon_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_desc  (fr_desc),
        .i_pop   (pop),
        .o_desc  (q_desc),
        .o_full  (full),
        .o_empty (empty)
    );

    tnon_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_desc  (q_desc),
        .i_empty (empty),
        .o_pop   (pop),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_kind  (o_m_tuser),
        .o_byte  (out_byte),
        .o_echo  (echo_on),
        .o_last  (o_m_tlast)
    );

    assign o_m_tdata = {7'd0, echo_on, out_byte};

endmodule
